// ----- hdl/mspd_pkg.sv -----
package mspd_pkg;

  // speed numerator and the bits it takes in the divider
  localparam int unsigned SPEED_SCALE = 1000000;
  localparam int unsigned SCALE_BITS  = 24;

  // shared divider: dividend/quotient shift register, two quotient bits per cycle
  localparam int unsigned DQ_BITS    = 72;
  localparam int unsigned STEP_BITS  = 6;
  localparam int unsigned SPD_STEPS  = SCALE_BITS / 2;
  localparam int unsigned DRV_STEPS  = DQ_BITS / 2;
  localparam int unsigned PWM_BITS   = 24;
  localparam int unsigned PWM_STEPS  = PWM_BITS / 2;
  localparam int unsigned PCT_DIV    = 100;

  // fixed point
  localparam int unsigned ACC_W      = 61;
  localparam int unsigned FRAC_BITS  = 40;
  localparam int unsigned DRV_CAP_BIT = 58;

  localparam logic [14:0] SPEED_MAX  = 15'h7FFF;
  localparam logic signed [18:0] INTEG_MAX = 19'sd65535;
  localparam logic [6:0]  DUTY_INIT  = 7'd30;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_SETPOINT     = 3'd0,
    REG_PROP_GAIN    = 3'd1,
    REG_INTEG_GAIN   = 3'd2,
    REG_DERIV_GAIN   = 3'd3,
    REG_DUTY_FLOOR   = 3'd4,
    REG_DUTY_CEILING = 3'd5,
    REG_WINDUP_LIMIT = 3'd6,
    REG_PWM_PERIOD   = 3'd7
  } cfg_reg_t;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SPD_DIV,
    ST_ERR,
    ST_MP,
    ST_MI1,
    ST_MI2,
    ST_MI3,
    ST_MD,
    ST_DSTART,
    ST_DDIV,
    ST_DUTY,
    ST_PM,
    ST_PSTART,
    ST_PDIV,
    ST_DONE
  } state_t;

  // divider control from the sequencer
  typedef struct packed {
    logic                 start;
    logic [STEP_BITS-1:0] steps;
  } div_ctl_t;

endpackage

// ----- hdl/motor_speed_pid_duty_core.sv -----
// one capture passes from its transfer to out_valid through the shared two-bit-per-cycle
// divider: 12 steps for speed (skipped when the period is zero), 36 for the derivative
// term and 12 for the pwm compare, and through the shared 25x18 multiplier.
// a timer-wrapped capture is dropped; in_ready returns once the result is
// handed to the output register. synchronous active-low reset loads the default gains
// and limits, duty 30, errors and integrator zero, and empties the output register.
module motor_speed_pid_duty_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [15:0]        in_period_count,
  input  logic               in_timer_wrapped,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [6:0]         out_duty_percent,
  output logic [15:0]        out_pwm_compare,
  output logic signed [15:0] out_speed_error,
  output logic [14:0]        out_measured_speed,
  output logic               out_zero_period,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [23:0]        cfg_data
);

  localparam int unsigned DQW  = mspd_pkg::DQ_BITS;
  localparam int unsigned AW   = mspd_pkg::ACC_W;
  localparam int unsigned FB   = mspd_pkg::FRAC_BITS;
  localparam int unsigned CAPB = mspd_pkg::DRV_CAP_BIT;

  // configuration
  logic [14:0] setpoint_r;
  logic [23:0] prop_gain_r, integ_gain_r, deriv_gain_r;
  logic [6:0]  duty_floor_r, duty_ceiling_r;
  logic [14:0] windup_limit_r;
  logic [15:0] pwm_period_r;

  // sequencer and loop state
  mspd_pkg::state_t  state_r, state_nxt;
  logic [15:0]        period_r;
  logic               zero_r;
  logic [14:0]        speed_r;
  logic signed [15:0] err_now_r, err_prev_r;
  logic signed [17:0] integ_r;
  logic [6:0]         duty_r;
  logic signed [AW-1:0] acc_r;
  logic signed [42:0] prod_r;
  logic [23:0]        lo_r;
  logic [15:0]        cmp_r;

  // output register
  logic               out_valid_r;
  logic [6:0]         out_duty_r;
  logic [15:0]        out_cmp_r;
  logic signed [15:0] out_err_r;
  logic [14:0]        out_speed_r;
  logic               out_zero_r;

  // divider hookup
  mspd_pkg::div_ctl_t div_ctl;
  logic [DQW-1:0]     div_dividend;
  logic [15:0]        div_divisor;
  logic               div_done;
  logic [DQW-1:0]     div_quot;

  mspd_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (div_ctl),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quot)
  );

  logic in_xfer;
  assign in_ready = (state_r == mspd_pkg::ST_IDLE);
  assign in_xfer  = in_valid && in_ready;

  // new error and integrator with anti-windup
  logic signed [15:0] err_new;
  logic signed [17:0] lim;
  logic               hold;
  logic signed [18:0] integ_sum;
  logic signed [17:0] integ_upd;

  always_comb begin
    err_new   = $signed({1'b0, setpoint_r}) - $signed({1'b0, speed_r});
    lim       = $signed({3'b0, windup_limit_r});
    hold      = ((integ_r <= -lim) && (err_new < 0)) ||
                ((integ_r >= lim) && (err_new > 0));
    integ_sum = $signed({integ_r[17], integ_r}) + $signed({{3{err_new[15]}}, err_new});
    if (integ_sum > mspd_pkg::INTEG_MAX) begin
      integ_upd = 18'(mspd_pkg::INTEG_MAX);
    end else if (integ_sum < -mspd_pkg::INTEG_MAX) begin
      integ_upd = 18'(-mspd_pkg::INTEG_MAX);
    end else begin
      integ_upd = integ_sum[17:0];
    end
  end

  // error difference for the derivative term
  logic signed [16:0] de;
  logic               de_neg;
  logic [15:0]        de_mag;

  always_comb begin
    de     = $signed({err_now_r[15], err_now_r}) - $signed({err_prev_r[15], err_prev_r});
    de_neg = de[16];
    de_mag = de_neg ? 16'(-de) : de[15:0];
  end

  // shared multiplier operand select
  logic signed [24:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [42:0] mul_p;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      mspd_pkg::ST_MP: begin
        mul_a = $signed({1'b0, prop_gain_r});
        mul_b = $signed({{2{err_now_r[15]}}, err_now_r});
      end
      mspd_pkg::ST_MI1: begin
        mul_a = $signed({1'b0, integ_gain_r});
        mul_b = integ_r;
      end
      mspd_pkg::ST_MI2: begin
        mul_a = $signed({9'b0, period_r});
        mul_b = prod_r[41:24];
      end
      mspd_pkg::ST_MI3: begin
        mul_a = $signed({1'b0, lo_r});
        mul_b = $signed({2'b0, period_r});
      end
      mspd_pkg::ST_MD: begin
        mul_a = $signed({1'b0, deriv_gain_r});
        mul_b = $signed({2'b0, de_mag});
      end
      mspd_pkg::ST_PM: begin
        mul_a = $signed({18'b0, duty_r});
        mul_b = $signed({2'b0, pwm_period_r});
      end
      default: begin
      end
    endcase
    mul_p = mul_a * mul_b;
  end

  // derivative magnitude with cap, and accumulator addend
  logic [CAPB:0]         dmag;
  logic signed [AW-1:0]  dterm;
  logic signed [AW-1:0]  acc_add;

  always_comb begin
    dmag  = (|div_quot[DQW-1:CAPB]) ? {1'b1, {CAPB{1'b0}}} : {1'b0, div_quot[CAPB-1:0]};
    dterm = $signed({{(AW-CAPB-1){1'b0}}, dmag});
    if (de_neg) begin
      dterm = -dterm;
    end
    acc_add = '0;
    unique case (state_r)
      mspd_pkg::ST_MI1:  acc_add = AW'(prod_r) <<< 16;
      mspd_pkg::ST_MI3:  acc_add = AW'(prod_r) <<< 24;
      mspd_pkg::ST_MD:   acc_add = AW'(prod_r);
      mspd_pkg::ST_DDIV: acc_add = dterm;
      default:           acc_add = '0;
    endcase
  end

  // truncate toward zero and clamp
  logic signed [AW-FB-1:0] dt_base;
  logic                    dt_fix;
  logic signed [AW-FB:0]   dt;
  logic [6:0]              duty_new;

  always_comb begin
    dt_base = acc_r[AW-1:FB];
    dt_fix  = acc_r[AW-1] && (|acc_r[FB-1:0]);
    dt      = {dt_base[AW-FB-1], dt_base} + {{(AW-FB){1'b0}}, dt_fix};
    priority if (dt < $signed({{(AW-FB-6){1'b0}}, duty_floor_r})) begin
      duty_new = duty_floor_r;
    end else if (dt > $signed({{(AW-FB-6){1'b0}}, duty_ceiling_r})) begin
      duty_new = duty_ceiling_r;
    end else begin
      duty_new = dt[6:0];
    end
  end

  // sequencer next state and divider control
  always_comb begin
    state_nxt     = state_r;
    div_ctl.start = 1'b0;
    div_ctl.steps = '0;
    div_dividend  = '0;
    div_divisor   = '0;
    unique case (state_r)
      mspd_pkg::ST_IDLE: begin
        if (in_xfer && !in_timer_wrapped) begin
          if (in_period_count == '0) begin
            state_nxt = mspd_pkg::ST_ERR;
          end else begin
            div_ctl.start = 1'b1;
            div_ctl.steps = mspd_pkg::STEP_BITS'(mspd_pkg::SPD_STEPS);
            div_dividend  = {mspd_pkg::SCALE_BITS'(mspd_pkg::SPEED_SCALE),
                             {(DQW-mspd_pkg::SCALE_BITS){1'b0}}};
            div_divisor   = in_period_count;
            state_nxt     = mspd_pkg::ST_SPD_DIV;
          end
        end
      end
      mspd_pkg::ST_SPD_DIV: if (div_done) state_nxt = mspd_pkg::ST_ERR;
      mspd_pkg::ST_ERR:     state_nxt = mspd_pkg::ST_MP;
      mspd_pkg::ST_MP:      state_nxt = mspd_pkg::ST_MI1;
      mspd_pkg::ST_MI1:     state_nxt = mspd_pkg::ST_MI2;
      mspd_pkg::ST_MI2:     state_nxt = mspd_pkg::ST_MI3;
      mspd_pkg::ST_MI3:     state_nxt = mspd_pkg::ST_MD;
      mspd_pkg::ST_MD:      state_nxt = mspd_pkg::ST_DSTART;
      mspd_pkg::ST_DSTART: begin
        div_ctl.start = 1'b1;
        div_ctl.steps = mspd_pkg::STEP_BITS'(mspd_pkg::DRV_STEPS);
        div_dividend  = {prod_r[39:0], {(DQW-40){1'b0}}};
        div_divisor   = zero_r ? 16'd1 : period_r;
        state_nxt     = mspd_pkg::ST_DDIV;
      end
      mspd_pkg::ST_DDIV:    if (div_done) state_nxt = mspd_pkg::ST_DUTY;
      mspd_pkg::ST_DUTY:    state_nxt = mspd_pkg::ST_PM;
      mspd_pkg::ST_PM:      state_nxt = mspd_pkg::ST_PSTART;
      mspd_pkg::ST_PSTART: begin
        div_ctl.start = 1'b1;
        div_ctl.steps = mspd_pkg::STEP_BITS'(mspd_pkg::PWM_STEPS);
        div_dividend  = {prod_r[mspd_pkg::PWM_BITS-1:0], {(DQW-mspd_pkg::PWM_BITS){1'b0}}};
        div_divisor   = 16'(mspd_pkg::PCT_DIV);
        state_nxt     = mspd_pkg::ST_PDIV;
      end
      mspd_pkg::ST_PDIV:    if (div_done) state_nxt = mspd_pkg::ST_DONE;
      mspd_pkg::ST_DONE:    if (!out_valid_r || out_ready) state_nxt = mspd_pkg::ST_IDLE;
      default:              state_nxt = mspd_pkg::ST_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mspd_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      setpoint_r     <= 15'd334;
      prop_gain_r    <= 24'd503316;
      integ_gain_r   <= 24'd1624300;
      deriv_gain_r   <= 24'd207590;
      duty_floor_r   <= 7'd20;
      duty_ceiling_r <= 7'd100;
      windup_limit_r <= 15'd200;
      pwm_period_r   <= 16'd3000;
    end else if (cfg_we) begin
      unique case (mspd_pkg::cfg_reg_t'(cfg_index))
        mspd_pkg::REG_SETPOINT:     setpoint_r     <= cfg_data[14:0];
        mspd_pkg::REG_PROP_GAIN:    prop_gain_r    <= cfg_data;
        mspd_pkg::REG_INTEG_GAIN:   integ_gain_r   <= cfg_data;
        mspd_pkg::REG_DERIV_GAIN:   deriv_gain_r   <= cfg_data;
        mspd_pkg::REG_DUTY_FLOOR:   duty_floor_r   <= cfg_data[6:0];
        mspd_pkg::REG_DUTY_CEILING: duty_ceiling_r <= cfg_data[6:0];
        mspd_pkg::REG_WINDUP_LIMIT: windup_limit_r <= cfg_data[14:0];
        mspd_pkg::REG_PWM_PERIOD:   pwm_period_r   <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  // loop state carried between captures
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      duty_r     <= mspd_pkg::DUTY_INIT;
      err_now_r  <= '0;
      err_prev_r <= '0;
      integ_r    <= '0;
    end else begin
      if (state_r == mspd_pkg::ST_ERR) begin
        err_prev_r <= err_now_r;
        err_now_r  <= err_new;
        if ((duty_r != duty_ceiling_r) && (duty_r != duty_floor_r) && !hold) begin
          integ_r <= integ_upd;
        end
      end
      if (state_r == mspd_pkg::ST_DUTY) begin
        duty_r <= duty_new;
      end
    end
  end

  // per-capture datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      mspd_pkg::ST_IDLE: begin
        if (in_xfer && !in_timer_wrapped) begin
          period_r <= in_period_count;
          zero_r   <= (in_period_count == '0);
          speed_r  <= mspd_pkg::SPEED_MAX;
        end
      end
      mspd_pkg::ST_SPD_DIV: begin
        if (div_done) begin
          speed_r <= (|div_quot[mspd_pkg::SCALE_BITS-1:15]) ? mspd_pkg::SPEED_MAX
                                                           : div_quot[14:0];
        end
      end
      mspd_pkg::ST_MP: begin
        prod_r <= mul_p;
        acc_r  <= $signed({{(AW-FB-7){1'b0}}, duty_r, {FB{1'b0}}});
      end
      mspd_pkg::ST_MI1, mspd_pkg::ST_MI3, mspd_pkg::ST_MD: begin
        prod_r <= mul_p;
        acc_r  <= acc_r + acc_add;
      end
      mspd_pkg::ST_MI2: begin
        lo_r   <= prod_r[23:0];
        prod_r <= mul_p;
      end
      mspd_pkg::ST_DDIV: begin
        if (div_done) begin
          acc_r <= acc_r + acc_add;
        end
      end
      mspd_pkg::ST_PM: begin
        prod_r <= mul_p;
      end
      mspd_pkg::ST_PDIV: begin
        if (div_done) begin
          cmp_r <= (|div_quot[mspd_pkg::PWM_BITS-1:16]) ? 16'hFFFF : div_quot[15:0];
        end
      end
      default: begin
      end
    endcase
  end

  // output register: result waits here while the next capture starts
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      if ((state_r == mspd_pkg::ST_DONE) && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == mspd_pkg::ST_DONE) && (!out_valid_r || out_ready)) begin
      out_duty_r  <= duty_r;
      out_cmp_r   <= cmp_r;
      out_err_r   <= err_now_r;
      out_speed_r <= speed_r;
      out_zero_r  <= zero_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_duty_percent   = out_duty_r;
  assign out_pwm_compare    = out_cmp_r;
  assign out_speed_error    = out_err_r;
  assign out_measured_speed = out_speed_r;
  assign out_zero_period    = out_zero_r;

endmodule

// ----- hdl/mspd_div.sv -----
module mspd_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mspd_pkg::div_ctl_t            ctl,
  input  logic [mspd_pkg::DQ_BITS-1:0]  dividend,
  input  logic [15:0]                   divisor,
  output logic                          done,
  output logic [mspd_pkg::DQ_BITS-1:0]  quotient
);

  localparam int unsigned DQW = mspd_pkg::DQ_BITS;

  logic [15:0]          rem_r, rem_nxt;
  logic [DQW-1:0]       dq_r, dq_nxt;
  logic [15:0]          div_r;
  logic [mspd_pkg::STEP_BITS-1:0] cnt_r;
  logic                 busy_r;
  logic                 done_r;

  logic [16:0]          t0, t1;
  logic                 ge0, ge1;
  logic [15:0]          rem_mid;

  // two restoring steps per cycle
  always_comb begin
    t0      = {rem_r, dq_r[DQW-1]};
    ge0     = t0 >= {1'b0, div_r};
    rem_mid = ge0 ? 16'(t0 - {1'b0, div_r}) : t0[15:0];
    t1      = {rem_mid, dq_r[DQW-2]};
    ge1     = t1 >= {1'b0, div_r};
    rem_nxt = ge1 ? 16'(t1 - {1'b0, div_r}) : t1[15:0];
    dq_nxt  = {dq_r[DQW-3:0], ge0, ge1};
  end

  // step counter and done pulse
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        busy_r <= 1'b1;
        cnt_r  <= ctl.steps;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == mspd_pkg::STEP_BITS'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // remainder and dividend/quotient shift register
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      rem_r <= '0;
      dq_r  <= dividend;
      div_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      dq_r  <= dq_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = dq_r;

endmodule

// ----- hdl/mspd_chk.sv -----
module mspd_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic [15:0]        in_period_count,
  input logic               in_timer_wrapped,
  input logic               out_valid,
  input logic               out_ready,
  input logic [6:0]         out_duty_percent,
  input logic [15:0]        out_pwm_compare,
  input logic signed [15:0] out_speed_error,
  input logic [14:0]        out_measured_speed,
  input logic               out_zero_period,
  input logic               cfg_we,
  input logic [2:0]         cfg_index,
  input logic [23:0]        cfg_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_duty_percent) &&
    $stable(out_pwm_compare) && $stable(out_speed_error))
    else $error("result changed while stalled");

  // a dropped capture leaves the block ready
  a_wrap_drop: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_timer_wrapped |=> in_ready)
    else $error("wrapped capture started an update");

  // a real capture keeps the block busy
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_timer_wrapped |=> !in_ready)
    else $error("ready during an update");

  // zero period reports saturated speed
  a_zero_speed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_zero_period |-> out_measured_speed == 15'h7FFF)
    else $error("zero period without saturated speed");

  // zero duty gives a zero compare value
  a_zero_cmp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_duty_percent == 7'd0) |-> out_pwm_compare == 16'd0)
    else $error("compare nonzero at zero duty");

endmodule

bind motor_speed_pid_duty_core mspd_chk u_mspd_chk (.*);

// ----- bench/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import mspd_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 100;
  localparam int MAX_REPORTS = 10;
  localparam longint unsigned SCALE = 1000000;
  localparam longint DTERM_CAP = 64'sd1 << 58;
  localparam longint Q40_ONE = 64'sd1 << 40;

  typedef struct {
    logic [15:0] period;
    bit          wrapped;
    bit          drain;
  } capture_t;

  typedef struct {
    logic [6:0]         duty;
    logic [15:0]        cmp;
    logic signed [15:0] err;
    logic [14:0]        speed;
    logic               zero;
  } duty_result_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [15:0]        in_period_count = '0;
  logic               in_timer_wrapped = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [6:0]         out_duty_percent;
  logic [15:0]        out_pwm_compare;
  logic signed [15:0] out_speed_error;
  logic [14:0]        out_measured_speed;
  logic               out_zero_period;
  logic               cfg_we = 1'b0;
  logic [2:0]         cfg_index = '0;
  logic [23:0]        cfg_data = '0;

  // predictor copy of the registers
  logic [14:0] sp_reg = 15'd334;
  logic [23:0] kp_reg = 24'd503316;
  logic [23:0] ki_reg = 24'd1624300;
  logic [23:0] kd_reg = 24'd207590;
  logic [6:0]  floor_reg = 7'd20;
  logic [6:0]  ceil_reg = 7'd100;
  logic [14:0] wlim_reg = 15'd200;
  logic [15:0] pwmp_reg = 16'd3000;

  // predictor copy of the loop state
  logic [6:0] duty_q = 7'd30;
  int         err_q = 0;
  int         err_prev_q = 0;
  int         integ_q = 0;

  capture_t     capture_q[$];
  duty_result_t expected_q[$];
  int           send_idle_pct = 0;
  int           recv_idle_pct = 0;
  int           mismatches = 0;
  int           stall_cycles = 0;

  motor_speed_pid_duty_core uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_period_count    (in_period_count),
    .in_timer_wrapped   (in_timer_wrapped),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_duty_percent   (out_duty_percent),
    .out_pwm_compare    (out_pwm_compare),
    .out_speed_error    (out_speed_error),
    .out_measured_speed (out_measured_speed),
    .out_zero_period    (out_zero_period),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  always #4 clk = ~clk;

  // one pid update for a capture that was not timer-wrapped
  function automatic duty_result_t predict_duty_update(logic [15:0] period_in);
    duty_result_t      r;
    longint unsigned   per, quo, rem, div, dmag, mag, frac, cmp_full;
    longint            dterm, acc, sum, whole;
    int                speed, e, de, lim;
    bit                zero, hold;
    per = period_in;
    zero = (per == 0);
    if (zero) begin
      speed = 32767;
    end else begin
      quo = SCALE / per;
      speed = (quo > 32767) ? 32767 : int'(quo);
    end
    e = int'(sp_reg) - speed;
    err_prev_q = err_q;
    err_q = e;

    // anti-windup: no accumulation at a duty limit or when pushing past the limit
    lim = int'(wlim_reg);
    if (duty_q != ceil_reg && duty_q != floor_reg) begin
      hold = (integ_q <= -lim && e < 0) || (integ_q >= lim && e > 0);
      if (!hold) begin
        integ_q = integ_q + e;
        if (integ_q > 65535) integ_q = 65535;
        if (integ_q < -65535) integ_q = -65535;
      end
    end

    // q40 increment: proportional, integral, derivative
    acc = longint'(kp_reg) * longint'(e) * 64'sd65536;
    acc = acc + longint'(ki_reg) * longint'(per) * longint'(integ_q);
    de = err_q - err_prev_q;
    if (de < 0) dmag = -de;
    else dmag = de;
    mag = dmag * kd_reg;
    div = zero ? 64'd1 : per;
    quo = mag / div;
    rem = mag % div;
    if (quo >= (64'd1 << 26)) begin
      dterm = DTERM_CAP;
    end else begin
      frac = (quo << 32) + (rem << 32) / div;
      dterm = (frac > DTERM_CAP) ? DTERM_CAP : longint'(frac);
    end
    if (de < 0) dterm = -dterm;
    acc = acc + dterm;

    // truncate toward zero, floor test first
    sum = longint'(duty_q) * Q40_ONE + acc;
    if (sum >= 0) whole = sum / Q40_ONE;
    else whole = -((-sum) / Q40_ONE);
    if (whole < longint'(floor_reg)) duty_q = floor_reg;
    else if (whole > longint'(ceil_reg)) duty_q = ceil_reg;
    else duty_q = whole[6:0];

    cmp_full = duty_q;
    cmp_full = cmp_full * pwmp_reg / 64'd100;
    r.duty = duty_q;
    r.cmp = (cmp_full > 64'd65535) ? 16'hFFFF : cmp_full[15:0];
    r.err = e[15:0];
    r.speed = speed[14:0];
    r.zero = zero;
    return r;
  endfunction

  // register write, mirrored into the predictor
  task automatic write_reg(cfg_reg_t idx, logic [23:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_SETPOINT:     sp_reg = val[14:0];
      REG_PROP_GAIN:    kp_reg = val;
      REG_INTEG_GAIN:   ki_reg = val;
      REG_DERIV_GAIN:   kd_reg = val;
      REG_DUTY_FLOOR:   floor_reg = val[6:0];
      REG_DUTY_CEILING: ceil_reg = val[6:0];
      REG_WINDUP_LIMIT: wlim_reg = val[14:0];
      REG_PWM_PERIOD:   pwmp_reg = val[15:0];
      default: ;
    endcase
  endtask

  // wait for all captures sent and all results back, then let the block settle
  task automatic wait_drained();
    @(negedge clk);
    while (capture_q.size() != 0 || in_valid || expected_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic add_capture(logic [15:0] p, bit w);
    capture_t c;
    c.period = p;
    c.wrapped = w;
    c.drain = 1'b0;
    capture_q.push_back(c);
  endtask

  function automatic logic [23:0] pick_gain(logic [23:0] nominal);
    logic [31:0] scaled;
    case ($urandom_range(0, 9))
      0: return 24'd0;
      1: return 24'hFFFFFF;
      2: return $urandom;
      default: begin
        scaled = nominal * $urandom_range(1, 12) / 4;
        return scaled[23:0];
      end
    endcase
  endfunction

  task automatic write_random_settings();
    logic [23:0] v;
    case ($urandom_range(0, 9))
      0: v = 24'd0;
      1: v = $urandom;
      default: v = $urandom_range(40, 2500);
    endcase
    write_reg(REG_SETPOINT, v);
    write_reg(REG_PROP_GAIN, pick_gain(24'd503316));
    write_reg(REG_INTEG_GAIN, pick_gain(24'd1624300));
    write_reg(REG_DERIV_GAIN, pick_gain(24'd207590));
    case ($urandom_range(0, 9))
      0: v = 24'd0;
      1: v = $urandom;
      2: v = 24'd100;
      default: v = $urandom_range(0, 35);
    endcase
    write_reg(REG_DUTY_FLOOR, v);
    case ($urandom_range(0, 9))
      0: v = 24'd100;
      1: v = $urandom;
      2: v = 24'd0;
      default: v = $urandom_range(65, 100);
    endcase
    write_reg(REG_DUTY_CEILING, v);
    case ($urandom_range(0, 9))
      0: v = 24'd0;
      1: v = $urandom;
      2: v = 24'd32767;
      default: v = $urandom_range(20, 3000);
    endcase
    write_reg(REG_WINDUP_LIMIT, v);
    case ($urandom_range(0, 9))
      0: v = 24'd0;
      1: v = $urandom;
      2: v = 24'd65535;
      default: v = $urandom_range(500, 8000);
    endcase
    write_reg(REG_PWM_PERIOD, v);
  endtask

  // mostly captures around the period that matches the setpoint
  function automatic logic [15:0] next_period();
    int t, j, p;
    t = (sp_reg != 0) ? int'(SCALE / sp_reg) : 0;
    case ($urandom_range(0, 19))
      0, 1, 2:  return $urandom;
      3, 4:     return $urandom_range(0, 40);
      5:        return 16'd0;
      default: begin
        if (t == 0 || t > 65535) return $urandom;
        j = t / 4 + 1;
        p = t - j + int'($urandom_range(0, 2 * j));
        if (p > 65535) p = 65535;
        return p[15:0];
      end
    endcase
  endfunction

  task automatic add_random_phase(int n_items);
    capture_t c;
    int       counted;
    counted = 0;
    while (counted < n_items) begin
      if ($urandom_range(0, 9) == 0) begin
        add_capture($urandom, 1'b1);
      end else begin
        c.period = next_period();
        c.wrapped = 1'b0;
        c.drain = (counted == n_items / 2);
        capture_q.push_back(c);
        counted++;
      end
    end
  endtask

  // input driver
  always @(posedge clk) begin
    capture_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_period_count <= '0;
      in_timer_wrapped <= 1'b0;
    end else begin
      if (in_valid && in_ready && !in_timer_wrapped)
        expected_q.push_back(predict_duty_update(in_period_count));
      if (in_valid && !in_ready) begin
        // payload held until the transfer
      end else if (capture_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct &&
                   !(capture_q[0].drain && expected_q.size() != 0)) begin
        nxt = capture_q.pop_front();
        in_valid <= 1'b1;
        in_period_count <= nxt.period;
        in_timer_wrapped <= nxt.wrapped;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    duty_result_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: result with nothing expected: duty %0d cmp %0d err %0d speed %0d",
                     $time, out_duty_percent, out_pwm_compare, out_speed_error,
                     out_measured_speed);
        end else begin
          want = expected_q.pop_front();
          if (out_duty_percent !== want.duty || out_pwm_compare !== want.cmp ||
              out_speed_error !== want.err || out_measured_speed !== want.speed ||
              out_zero_period !== want.zero) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("%0t: mismatch (exp/got) duty %0d/%0d cmp %0d/%0d err %0d/%0d %s",
                       $time, want.duty, out_duty_percent, want.cmp, out_pwm_compare,
                       want.err, out_speed_error,
                       $sformatf("speed %0d/%0d zero %0b/%0b", want.speed,
                                 out_measured_speed, want.zero, out_zero_period));
          end
        end
      end
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    send_idle_pct = 7;
    recv_idle_pct = 48;

    // reset settings: zero period, speed saturation edges, near setpoint, wrapped
    add_capture(16'd0, 1'b0);
    add_capture(16'd1, 1'b0);
    add_capture(16'd30, 1'b0);
    add_capture(16'd31, 1'b0);
    add_capture(16'h5555, 1'b1);
    add_capture(16'd2994, 1'b0);
    add_capture(16'd3000, 1'b0);
    add_capture(16'hFFFF, 1'b0);
    add_capture(16'd0, 1'b1);
    add_capture(16'hAAAA, 1'b0);
    wait_drained();

    // frozen duty, wide limits: integrator runs into the windup limit
    write_reg(REG_PROP_GAIN, 24'd0);
    write_reg(REG_INTEG_GAIN, 24'd0);
    write_reg(REG_DERIV_GAIN, 24'd0);
    write_reg(REG_DUTY_FLOOR, 24'd0);
    write_reg(REG_DUTY_CEILING, 24'hFFFFFF);
    write_reg(REG_WINDUP_LIMIT, 24'd32767);
    write_reg(REG_SETPOINT, 24'd0);
    write_reg(REG_PWM_PERIOD, 24'hFFFFFF);
    @(negedge clk);
    repeat (3) add_capture(16'd1, 1'b0);
    add_capture(16'hFFFF, 1'b0);
    add_capture(16'd0, 1'b0);
    wait_drained();

    // maximum gains: duty to the ceiling, compare saturation, zero windup limit
    write_reg(REG_SETPOINT, 24'hFFFFFF);
    write_reg(REG_PROP_GAIN, 24'hFFFFFF);
    write_reg(REG_INTEG_GAIN, 24'hFFFFFF);
    write_reg(REG_DERIV_GAIN, 24'hFFFFFF);
    write_reg(REG_WINDUP_LIMIT, 24'd0);
    @(negedge clk);
    add_capture(16'hFFFF, 1'b0);
    add_capture(16'd0, 1'b0);
    add_capture(16'd1, 1'b0);
    add_capture(16'hFFFF, 1'b0);
    wait_drained();

    // floor above ceiling
    write_reg(REG_SETPOINT, 24'd334);
    write_reg(REG_PROP_GAIN, 24'd503316);
    write_reg(REG_INTEG_GAIN, 24'd1624300);
    write_reg(REG_DERIV_GAIN, 24'd207590);
    write_reg(REG_DUTY_FLOOR, 24'd90);
    write_reg(REG_DUTY_CEILING, 24'd10);
    write_reg(REG_WINDUP_LIMIT, 24'd200);
    write_reg(REG_PWM_PERIOD, 24'd3000);
    @(negedge clk);
    add_capture(16'd2994, 1'b0);
    add_capture(16'd100, 1'b0);
    add_capture(16'hFFFF, 1'b0);
    add_capture(16'd0, 1'b0);
    wait_drained();

    // random settings and captures, idling swapped then off
    for (int ph = 0; ph < 10; ph++) begin
      if (ph == 4) begin
        send_idle_pct = 48;
        recv_idle_pct = 7;
      end else if (ph == 7) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_random_settings();
      @(negedge clk);
      add_random_phase(75);
      wait_drained();
    end

    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
